@@ design/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the topological sorter
// Command and status bundles between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int VC_W  = 7;   // vertex count register and vertex counters
    localparam int VTX_W = 6;   // vertex index field

    localparam logic ACT_EDGE = 1'b0;
    localparam logic ACT_RUN  = 1'b1;

    typedef struct packed {
        logic load;       // store an incoming edge
        logic vi_clr;     // vertex counter to zero
        logic vi_inc;     // vertex counter up
        logic clr_wr;     // clear node entry at vertex counter
        logic e_clr;      // edge counter to zero
        logic e_inc;      // edge counter up
        logic edge_rd;    // read edge store at edge counter
        logic cnt_nrd;    // read node entry of edge target (count pass)
        logic cnt_wr;     // bump in-degree of edge target
        logic scan_rd;    // read node entry at vertex counter
        logic scan_take;  // mark vertex, seed queue
        logic q_rd;       // read queue head
        logic pop;        // take head vertex as current, emit previous
        logic walk_nrd;   // read node entry of edge target (walk pass)
        logic walk_wr;    // decrement target, enqueue on zero
        logic finish;     // emit final result, clear run state
    } tks_cmd_t;

    typedef struct packed {
        logic e_done;     // edge counter reached edge total
        logic clr_last;   // clear pass at last node entry
        logic scan_done;  // vertex counter reached active count
        logic cnt_hit;    // edge lies inside active range
        logic walk_hit;   // edge leaves current vertex, target in range
        logic zero_free;  // node entry has in-degree zero and no mark
        logic q_empty;    // queue head met tail
        logic pop_ok;     // pending result can move to output
        logic out_free;   // output register can take a result
    } tks_sts_t;

endpackage

@@ design/tks_ctrl.sv @@
// ----------------------------------------------------------------------------
// tks_ctrl: sequencer of the topological sorter
// Steps the load, clear, count, scan and walk passes of one run.
// ----------------------------------------------------------------------------
module tks_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_action,
    output logic              in_ready,
    input  tks_pkg::tks_sts_t sts,
    output tks_pkg::tks_cmd_t cmd
);
    import tks_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLR      = 4'd1;
    localparam logic [3:0] ST_CNT_RD   = 4'd2;
    localparam logic [3:0] ST_CNT_NRD  = 4'd3;
    localparam logic [3:0] ST_CNT_WR   = 4'd4;
    localparam logic [3:0] ST_SCAN_RD  = 4'd5;
    localparam logic [3:0] ST_SCAN_CHK = 4'd6;
    localparam logic [3:0] ST_DEQ      = 4'd7;
    localparam logic [3:0] ST_POP      = 4'd8;
    localparam logic [3:0] ST_WALK_RD  = 4'd9;
    localparam logic [3:0] ST_WALK_CHK = 4'd10;
    localparam logic [3:0] ST_WALK_WR  = 4'd11;
    localparam logic [3:0] ST_FINISH   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == ACT_EDGE)
                    begin
                        cmd.load = 1'b1;
                    end
                    else
                    begin
                        cmd.vi_clr = 1'b1;
                        state_next = ST_CLR;
                    end
                end
            end
            ST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.vi_clr = 1'b1;
                    cmd.e_clr  = 1'b1;
                    state_next = ST_CNT_RD;
                end
                else
                begin
                    cmd.vi_inc = 1'b1;
                end
            end
            ST_CNT_RD:
            begin
                if (sts.e_done)
                begin
                    cmd.vi_clr = 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_CNT_NRD;
                end
            end
            ST_CNT_NRD:
            begin
                if (sts.cnt_hit)
                begin
                    cmd.cnt_nrd = 1'b1;
                    state_next   = ST_CNT_WR;
                end
                else
                begin
                    cmd.e_inc  = 1'b1;
                    state_next = ST_CNT_RD;
                end
            end
            ST_CNT_WR:
            begin
                cmd.cnt_wr = 1'b1;
                cmd.e_inc  = 1'b1;
                state_next = ST_CNT_RD;
            end
            ST_SCAN_RD:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (sts.zero_free)
                begin
                    cmd.scan_take = 1'b1;
                    state_next    = ST_DEQ;
                end
                else
                begin
                    cmd.vi_inc = 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DEQ:
            begin
                if (sts.q_empty)
                begin
                    cmd.vi_inc = 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    cmd.q_rd   = 1'b1;
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                // hold while the previous result waits for the output
                if (sts.pop_ok)
                begin
                    cmd.pop    = 1'b1;
                    cmd.e_clr  = 1'b1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                if (sts.e_done)
                begin
                    state_next = ST_DEQ;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK:
            begin
                if (sts.walk_hit)
                begin
                    cmd.walk_nrd = 1'b1;
                    state_next   = ST_WALK_WR;
                end
                else
                begin
                    cmd.e_inc  = 1'b1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_WR:
            begin
                cmd.walk_wr = 1'b1;
                cmd.e_inc   = 1'b1;
                state_next  = ST_WALK_RD;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/tks_dp.sv @@
// ----------------------------------------------------------------------------
// tks_dp: datapath of the topological sorter
// Edge store, node table (in-degree and mark), work queue, counters and
// the output register.
// ----------------------------------------------------------------------------
module tks_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [tks_pkg::VC_W-1:0]  cfg_wdata,
    input  logic [tks_pkg::VTX_W-1:0] in_src,
    input  logic [tks_pkg::VTX_W-1:0] in_dst,
    input  tks_pkg::tks_cmd_t         cmd,
    output tks_pkg::tks_sts_t         sts,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [tks_pkg::VTX_W-1:0] out_vertex,
    output logic                      out_valid_res,
    output logic                      out_last,
    output logic                      out_cycle,
    output logic                      out_rejected
);
    import tks_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int ECW = $clog2(MAX_EDGES + 1);

    // Storage
    logic [VTX_W-1:0] esrc_mem [MAX_EDGES];
    logic [VTX_W-1:0] edst_mem [MAX_EDGES];
    logic [ECW-1:0]   deg_mem  [MAX_VERTICES];
    logic             vis_mem  [MAX_VERTICES];
    logic [VTX_W-1:0] q_mem    [MAX_VERTICES];

    logic [VC_W-1:0]  vcount_reg;
    logic [ECW-1:0]   edge_total_reg;
    logic             rejected_reg;
    logic [ECW-1:0]   e_idx_reg;
    logic [VC_W-1:0]  vi_reg;
    logic [VC_W-1:0]  head_reg;
    logic [VC_W-1:0]  tail_reg;
    logic [VC_W-1:0]  emitted_reg;
    logic [VTX_W-1:0] cur_reg;
    logic [VTX_W-1:0] pend_reg;
    logic             pend_valid_reg;
    logic [VTX_W-1:0] erd_src_reg;
    logic [VTX_W-1:0] erd_dst_reg;
    logic [ECW-1:0]   nrd_deg_reg;
    logic             nrd_vis_reg;
    logic [VTX_W-1:0] qrd_reg;
    logic             out_valid_reg;
    logic [VTX_W-1:0] out_vertex_reg;
    logic             out_valid_res_reg;
    logic             out_last_reg;
    logic             out_cycle_reg;
    logic             out_rejected_reg;

    logic [VC_W-1:0]  nv;
    logic             load_bad;
    logic             load_ok;
    logic             out_free;
    logic             push_mid;
    logic [ECW-1:0]   dec_deg;
    logic             enq;
    logic             node_we;
    logic [AW-1:0]    node_waddr;
    logic [ECW-1:0]   node_wdeg;
    logic             node_wvis;
    logic             node_re;
    logic [AW-1:0]    node_raddr;

    // Active vertex count, capped at the table size
    assign nv = (vcount_reg > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vcount_reg;

    assign load_bad = (edge_total_reg == ECW'(MAX_EDGES))
                    || ({1'b0, in_src} >= nv) || ({1'b0, in_dst} >= nv);
    assign load_ok  = cmd.load && !load_bad;

    assign out_free = !out_valid_reg || out_ready;
    assign push_mid = cmd.pop && pend_valid_reg;

    // Walk update of the target entry
    assign dec_deg = (nrd_deg_reg != '0) ? nrd_deg_reg - ECW'(1) : '0;
    assign enq     = !nrd_vis_reg && (dec_deg == '0);

    // Node table port selection
    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = erd_dst_reg[AW-1:0];
        node_wdeg  = '0;
        node_wvis  = 1'b0;
        if (cmd.clr_wr)
        begin
            node_we    = 1'b1;
            node_waddr = vi_reg[AW-1:0];
        end
        else if (cmd.cnt_wr)
        begin
            node_we   = 1'b1;
            node_wdeg = nrd_deg_reg + ECW'(1);
            node_wvis = nrd_vis_reg;
        end
        else if (cmd.scan_take)
        begin
            node_we    = 1'b1;
            node_waddr = vi_reg[AW-1:0];
            node_wvis  = 1'b1;
        end
        else if (cmd.walk_wr)
        begin
            node_we   = 1'b1;
            node_wdeg = dec_deg;
            node_wvis = nrd_vis_reg || enq;
        end
    end

    assign node_re    = cmd.cnt_nrd || cmd.walk_nrd || cmd.scan_rd;
    assign node_raddr = cmd.scan_rd ? vi_reg[AW-1:0] : erd_dst_reg[AW-1:0];

    // Edge store
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            esrc_mem[edge_total_reg[EAW-1:0]] <= in_src;
            edst_mem[edge_total_reg[EAW-1:0]] <= in_dst;
        end
        if (cmd.edge_rd)
        begin
            erd_src_reg <= esrc_mem[e_idx_reg[EAW-1:0]];
            erd_dst_reg <= edst_mem[e_idx_reg[EAW-1:0]];
        end
    end

    // Node table
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            deg_mem[node_waddr] <= node_wdeg;
            vis_mem[node_waddr] <= node_wvis;
        end
        if (node_re)
        begin
            nrd_deg_reg <= deg_mem[node_raddr];
            nrd_vis_reg <= vis_mem[node_raddr];
        end
    end

    // Work queue
    always_ff @(posedge clk)
    begin
        if (cmd.scan_take)
        begin
            q_mem[0] <= vi_reg[VTX_W-1:0];
        end
        else if (cmd.walk_wr && enq)
        begin
            q_mem[tail_reg[AW-1:0]] <= erd_dst_reg;
        end
        if (cmd.q_rd)
        begin
            qrd_reg <= q_mem[head_reg[AW-1:0]];
        end
    end

    // Current vertex and pending result payload
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            cur_reg  <= qrd_reg;
            pend_reg <= qrd_reg;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (push_mid)
        begin
            out_vertex_reg    <= pend_reg;
            out_valid_res_reg <= 1'b1;
            out_last_reg      <= 1'b0;
            out_cycle_reg     <= 1'b0;
            out_rejected_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_vertex_reg    <= pend_valid_reg ? pend_reg : '0;
            out_valid_res_reg <= pend_valid_reg;
            out_last_reg      <= 1'b1;
            out_cycle_reg     <= (emitted_reg < nv);
            out_rejected_reg  <= rejected_reg;
        end
    end

    // Control registers and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= VC_W'(64);
            edge_total_reg <= '0;
            rejected_reg   <= 1'b0;
            e_idx_reg      <= '0;
            vi_reg         <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            emitted_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end

            if (load_ok)
            begin
                edge_total_reg <= edge_total_reg + ECW'(1);
            end
            else if (cmd.finish)
            begin
                edge_total_reg <= '0;
            end

            if (cmd.load && load_bad)
            begin
                rejected_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                rejected_reg <= 1'b0;
            end

            if (cmd.e_clr)
            begin
                e_idx_reg <= '0;
            end
            else if (cmd.e_inc)
            begin
                e_idx_reg <= e_idx_reg + ECW'(1);
            end

            if (cmd.vi_clr)
            begin
                vi_reg <= '0;
            end
            else if (cmd.vi_inc)
            begin
                vi_reg <= vi_reg + VC_W'(1);
            end

            // restart the queue for each seed vertex
            if (cmd.scan_take)
            begin
                head_reg <= '0;
                tail_reg <= VC_W'(1);
            end
            else
            begin
                if (cmd.pop)
                begin
                    head_reg <= head_reg + VC_W'(1);
                end
                if (cmd.walk_wr && enq)
                begin
                    tail_reg <= tail_reg + VC_W'(1);
                end
            end

            if (cmd.pop)
            begin
                emitted_reg    <= emitted_reg + VC_W'(1);
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                emitted_reg    <= '0;
                pend_valid_reg <= 1'b0;
            end

            if (push_mid || cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status to the sequencer
    always_comb
    begin
        sts.e_done    = (e_idx_reg == edge_total_reg);
        sts.clr_last  = (vi_reg == VC_W'(MAX_VERTICES - 1));
        sts.scan_done = (vi_reg == nv);
        sts.cnt_hit   = ({1'b0, erd_src_reg} < nv) && ({1'b0, erd_dst_reg} < nv);
        sts.walk_hit  = (erd_src_reg == cur_reg) && ({1'b0, erd_dst_reg} < nv);
        sts.zero_free = (nrd_deg_reg == '0) && !nrd_vis_reg;
        sts.q_empty   = (head_reg == tail_reg);
        sts.pop_ok    = !pend_valid_reg || out_free;
        sts.out_free  = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign out_vertex    = out_vertex_reg;
    assign out_valid_res = out_valid_res_reg;
    assign out_last      = out_last_reg;
    assign out_cycle     = out_cycle_reg;
    assign out_rejected  = out_rejected_reg;

    // Checks
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= ECW'(MAX_EDGES))
        else $error("edge total beyond store size");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (edge_total_reg == '0) && !rejected_reg && !pend_valid_reg)
        else $error("run state not cleared after final result");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= VC_W'(MAX_VERTICES))
        else $error("more vertices emitted than exist");

endmodule

@@ design/topological_sort_kahn_top.sv @@
// ----------------------------------------------------------------------------
// topological_sort_kahn_top: Kahn topological sorter
// Loads directed edges, then orders the vertices on a run item.
//
// Channel   Dir  Contents
// s_axis    in   tdata[5:0] src_vertex, [11:6] dst_vertex; tuser action
// m_axis    out  tdata[5:0] vertex, [6] cycle_found, [7] edge_rejected;
//                tuser valid_res; tlast last
// cfg       in   cfg_we, cfg_wdata = vertex_count
//
// An edge item is stored without leaving the idle state. A run item clears
// the node table, counts in-degrees over the stored edges, scans the
// vertices, and for each emitted vertex walks all stored edges.
// Reset is asynchronous, active low. The input is held off during a run;
// a stalled output holds the walk at its next result.
// ----------------------------------------------------------------------------
module topological_sort_kahn_top #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // src_vertex, dst_vertex, zero fill
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // vertex, cycle_found, edge_rejected
    output logic        m_axis_tuser,   // valid_res
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);
    import tks_pkg::*;

    tks_cmd_t         cmd;
    tks_sts_t         sts;
    logic             in_ready;
    logic [VTX_W-1:0] out_vertex;
    logic             out_cycle;
    logic             out_rejected;

    assign s_axis_tready = in_ready;

    tks_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tks_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_src        (s_axis_tdata[5:0]),
        .in_dst        (s_axis_tdata[11:6]),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_vertex    (out_vertex),
        .out_valid_res (m_axis_tuser),
        .out_last      (m_axis_tlast),
        .out_cycle     (out_cycle),
        .out_rejected  (out_rejected)
    );

    assign m_axis_tdata = {out_rejected, out_cycle, out_vertex};

endmodule
